// ===== rtl/assert_macros.svh =====
// assertion helpers shared by the rtl files
// both expect a clock named clk and a synchronous reset named rst in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every edge outside reset
`define ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("%m: check failed");

// consequent must hold at the edge that follows the antecedent
`define ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

// ===== rtl/i2cm_pkg.sv =====
package i2cm_pkg;

  localparam int DELAY_BITS = 16;
  localparam logic [15:0] HALF_PERIOD_RESET = 16'd2000;
  localparam logic [DELAY_BITS-1:0] DELAY_MAX = '1;

  // command codes
  localparam logic [2:0] OP_TICK  = 3'd0;
  localparam logic [2:0] OP_START = 3'd1;
  localparam logic [2:0] OP_ADDR  = 3'd2;
  localparam logic [2:0] OP_WRITE = 3'd3;
  localparam logic [2:0] OP_READ  = 3'd4;
  localparam logic [2:0] OP_STOP  = 3'd5;

  // configuration register indexes
  localparam logic REG_HALF_PERIOD = 1'b0;
  localparam logic REG_TARGET_ADDR = 1'b1;

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] data_byte;
    logic       read_not_write;
    logic       send_nack;
    logic       sda_in;
  } item_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       nack_seen;
    logic       rejected;
  } result_t;

  // phase length: zero acts as one tick, long values saturate to the counter range
  function automatic logic [DELAY_BITS-1:0] load_value(input logic [15:0] hp);
    logic [31:0] wide;
    logic [DELAY_BITS-1:0] val;
    wide = 32'(hp);
    if (wide > 32'(DELAY_MAX)) begin
      val = DELAY_MAX;
    end else begin
      val = DELAY_BITS'(wide);
    end
    if (val == '0) begin
      val = DELAY_BITS'(1);
    end
    return val;
  endfunction

endpackage

// ===== rtl/i2cm_engine.sv =====
`include "assert_macros.svh"

module i2cm_engine (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  i2cm_pkg::item_t   item,
  input  logic [15:0]       half_period,
  input  logic [6:0]        target_address,
  output i2cm_pkg::result_t res
);
  import i2cm_pkg::*;

  localparam logic [3:0] PH_IDLE   = 4'd0;
  localparam logic [3:0] PH_ST_A   = 4'd1;
  localparam logic [3:0] PH_ST_B   = 4'd2;
  localparam logic [3:0] PH_ST_C   = 4'd3;
  localparam logic [3:0] PH_SP_A   = 4'd4;
  localparam logic [3:0] PH_SP_B   = 4'd5;
  localparam logic [3:0] PH_SP_C   = 4'd6;
  localparam logic [3:0] PH_WR_SET = 4'd7;
  localparam logic [3:0] PH_WR_HI  = 4'd8;
  localparam logic [3:0] PH_WR_LO  = 4'd9;
  localparam logic [3:0] PH_WA_HI  = 4'd10;
  localparam logic [3:0] PH_WA_LO  = 4'd11;
  localparam logic [3:0] PH_RD_HI  = 4'd12;
  localparam logic [3:0] PH_RD_LO  = 4'd13;
  localparam logic [3:0] PH_RA_HI  = 4'd14;
  localparam logic [3:0] PH_RA_LO  = 4'd15;

  logic [3:0]            phase, phase_next;
  logic [3:0]            bit_index, bit_index_next;
  logic [DELAY_BITS-1:0] delay_count, delay_count_next;
  logic [7:0]            shift_reg, shift_reg_next;
  logic                  scl_level, scl_level_next;
  logic                  sda_level, sda_level_next;
  logic                  nack_flag, nack_flag_next;
  logic                  ack_choice, ack_choice_next;
  logic [7:0]            received, received_next;
  logic [DELAY_BITS-1:0] load;
  logic                  scl_now, sda_now, rej, done;

  always_comb begin
    phase_next       = phase;
    bit_index_next   = bit_index;
    delay_count_next = delay_count;
    shift_reg_next   = shift_reg;
    scl_level_next   = scl_level;
    sda_level_next   = sda_level;
    nack_flag_next   = nack_flag;
    ack_choice_next  = ack_choice;
    received_next    = received;
    rej              = 1'b0;
    done             = 1'b0;
    load             = load_value(half_period);

    // command entry, first phase starts on this same tick
    if (item.op inside {[OP_START:OP_STOP]}) begin
      if (phase != PH_IDLE) begin
        rej = 1'b1;
      end else begin
        case (item.op)
          OP_START: begin
            phase_next = PH_ST_A; delay_count_next = load;
            scl_level_next = 1'b1; sda_level_next = 1'b1;
          end
          OP_ADDR, OP_WRITE: begin
            shift_reg_next = (item.op == OP_ADDR) ?
                             {target_address, item.read_not_write} : item.data_byte;
            bit_index_next = 4'd7;
            phase_next = PH_WR_SET; delay_count_next = load;
            scl_level_next = 1'b0; sda_level_next = shift_reg_next[7];
          end
          OP_READ: begin
            shift_reg_next = '0;
            bit_index_next = 4'd7;
            ack_choice_next = item.send_nack;
            phase_next = PH_RD_HI; delay_count_next = load;
            scl_level_next = 1'b1; sda_level_next = 1'b1;
          end
          OP_STOP: begin
            phase_next = PH_SP_A; delay_count_next = load;
            scl_level_next = 1'b0; sda_level_next = 1'b0;
          end
          default: ;
        endcase
      end
    end

    scl_now = scl_level_next;
    sda_now = sda_level_next;

    // phase countdown and end-of-phase step
    if (phase_next != PH_IDLE) begin
      if (delay_count_next != '0) begin
        delay_count_next = delay_count_next - DELAY_BITS'(1);
      end
      if (delay_count_next == '0) begin
        case (phase_next)
          PH_ST_A: begin
            phase_next = PH_ST_B; delay_count_next = load;
            scl_level_next = 1'b1; sda_level_next = 1'b0;
          end
          PH_ST_B: begin
            phase_next = PH_ST_C; delay_count_next = load;
            scl_level_next = 1'b0; sda_level_next = 1'b0;
          end
          PH_SP_A: begin
            phase_next = PH_SP_B; delay_count_next = load;
            scl_level_next = 1'b1; sda_level_next = 1'b0;
          end
          PH_SP_B: begin
            phase_next = PH_SP_C; delay_count_next = load;
            scl_level_next = 1'b1; sda_level_next = 1'b1;
          end
          PH_WR_SET: begin
            phase_next = PH_WR_HI; delay_count_next = load;
            scl_level_next = 1'b1;
          end
          PH_WR_HI: begin
            phase_next = PH_WR_LO; delay_count_next = load;
            scl_level_next = 1'b0;
          end
          PH_WR_LO: begin
            if (bit_index_next == 4'd0) begin
              phase_next = PH_WA_HI; delay_count_next = load;
              scl_level_next = 1'b1; sda_level_next = 1'b1;
            end else begin
              bit_index_next = bit_index_next - 4'd1;
              phase_next = PH_WR_SET; delay_count_next = load;
              scl_level_next = 1'b0; sda_level_next = shift_reg_next[bit_index_next[2:0]];
            end
          end
          PH_WA_HI: begin
            // ack slot sampled at the end of scl high
            nack_flag_next = item.sda_in;
            phase_next = PH_WA_LO; delay_count_next = load;
            scl_level_next = 1'b0; sda_level_next = 1'b1;
          end
          PH_RD_HI: begin
            shift_reg_next = {shift_reg_next[6:0], item.sda_in};
            phase_next = PH_RD_LO; delay_count_next = load;
            scl_level_next = 1'b0; sda_level_next = 1'b1;
          end
          PH_RD_LO: begin
            if (bit_index_next == 4'd0) begin
              phase_next = PH_RA_HI; delay_count_next = load;
              scl_level_next = 1'b1; sda_level_next = ack_choice_next;
            end else begin
              bit_index_next = bit_index_next - 4'd1;
              phase_next = PH_RD_HI; delay_count_next = load;
              scl_level_next = 1'b1; sda_level_next = 1'b1;
            end
          end
          PH_RA_HI: begin
            phase_next = PH_RA_LO; delay_count_next = load;
            scl_level_next = 1'b0; sda_level_next = ack_choice_next;
          end
          PH_RA_LO: begin
            received_next = shift_reg_next;
            phase_next = PH_IDLE;
            done = 1'b1;
          end
          default: begin
            // last phase of start, stop and ack receive
            phase_next = PH_IDLE;
            done = 1'b1;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      bit_index   <= '0;
      delay_count <= '0;
      shift_reg   <= '0;
      scl_level   <= 1'b1;
      sda_level   <= 1'b1;
      nack_flag   <= 1'b0;
      ack_choice  <= 1'b0;
      received    <= '0;
    end else if (accept) begin
      phase       <= phase_next;
      bit_index   <= bit_index_next;
      delay_count <= delay_count_next;
      shift_reg   <= shift_reg_next;
      scl_level   <= scl_level_next;
      sda_level   <= sda_level_next;
      nack_flag   <= nack_flag_next;
      ack_choice  <= ack_choice_next;
      received    <= received_next;
    end
  end

  always_comb begin
    res.scl_out   = scl_now;
    res.sda_out   = sda_now;
    res.busy_res  = (phase_next != PH_IDLE);
    res.done_res  = done;
    res.rx_byte   = received_next;
    res.nack_seen = nack_flag_next;
    res.rejected  = rej;
  end

  `ASSERT_ALWAYS(a_active_count_nonzero, (phase == PH_IDLE) || (delay_count != '0))
  `ASSERT_ALWAYS(a_bit_index_range, bit_index <= 4'd7)
  `ASSERT_ALWAYS(a_done_not_busy, !(res.done_res && res.busy_res))
  `ASSERT_ALWAYS(a_reject_only_busy, !res.rejected || (phase != PH_IDLE))

endmodule

// ===== rtl/i2c_master_byte_engine.sv =====
// i2c master byte engine
// each transfer on the s_ channel is one bus tick with an optional command
// (tick only, start, address, write, read, stop); each tick gives exactly one
// transfer on the m_ channel with the scl/sda levels of that tick, busy, done,
// last received byte, nack flag and the rejected flag for a command given while busy.
// every bus phase lasts half_period ticks (apb register 0, zero acts as one);
// register 1 holds the seven-bit slave address sent by the address command.
// one tick is accepted every clock cycle while s_tready is high; its result is formed from
// the state registers and lands in the output register, or in the skid stage while that one is full.
// the output register plus a one-entry skid stage let s_tready stay high while
// one result waits; s_tready drops only when both hold results, and rises again
// as soon as the receiver takes one, so no result is lost or repeated.
// synchronous reset returns the engine to idle with scl and sda released high,
// half_period to 2000 and the address to zero; the output stages empty.
// configuration must be written only while no command is in progress; the block does not enforce it.
module i2c_master_byte_engine (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // op[2:0], data_byte[10:3], read_not_write[11], send_nack[12], sda_in[13]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // scl_out[0], sda_out[1], busy_res[2], done_res[3], rx_byte[11:4],
                                 // nack_seen[12], rejected[13]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import i2cm_pkg::*;

  logic [15:0] half_period;
  logic [6:0]  target_address;
  item_t       item;
  result_t     res;
  result_t     out_data, skid_data;
  logic        out_valid, skid_valid;
  logic        push, pop, cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_period    <= HALF_PERIOD_RESET;
      target_address <= '0;
    end else if (cfg_write) begin
      case (paddr[2])
        REG_HALF_PERIOD: half_period    <= pwdata[15:0];
        REG_TARGET_ADDR: target_address <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_HALF_PERIOD: prdata = {16'd0, half_period};
      REG_TARGET_ADDR: prdata = {25'd0, target_address};
      default:         prdata = '0;
    endcase
  end

  always_comb begin
    item.op             = s_tdata[2:0];
    item.data_byte      = s_tdata[10:3];
    item.read_not_write = s_tdata[11];
    item.send_nack      = s_tdata[12];
    item.sda_in         = s_tdata[13];
  end

  assign s_tready = !skid_valid;
  assign push     = s_tvalid && s_tready;
  assign pop      = m_tvalid && m_tready;

  i2cm_engine u_engine (
    .clk            (clk),
    .rst            (rst),
    .accept         (push),
    .item           (item),
    .half_period    (half_period),
    .target_address (target_address),
    .res            (res)
  );

  // output register with a one-entry skid behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid) begin
      out_valid <= push;
    end else if (pop) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || (pop && !skid_valid)) begin
      out_data <= res;
    end else if (pop) begin
      out_data <= skid_data;
    end
    if (out_valid && !pop && push) begin
      skid_data <= res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {2'b00, out_data.rejected, out_data.nack_seen, out_data.rx_byte,
                     out_data.done_res, out_data.busy_res, out_data.sda_out,
                     out_data.scl_out};

  `ASSERT_ALWAYS(a_skid_behind_out, !skid_valid || out_valid)
  `ASSERT_NEXT(a_push_lands, push, out_valid)
  `ASSERT_NEXT(a_full_holds, skid_valid && !pop, skid_valid && out_valid)

endmodule

// ===== verif/tb.sv =====
module tb;
  import i2cm_pkg::*;

  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int HOLD_CYCLES = 300;
  localparam int RAND_PER_SETTING = 60;

  // op codes outside the command set, treated as plain ticks
  localparam logic [2:0] OP_SPARE_LO = 3'd6;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;

  typedef enum logic [3:0] {
    S_IDLE, S_START_A, S_START_B, S_START_C, S_STOP_A, S_STOP_B, S_STOP_C,
    S_TX_SETUP, S_TX_HIGH, S_TX_LOW, S_TX_ACK_HIGH, S_TX_ACK_LOW,
    S_RX_HIGH, S_RX_LOW, S_RX_ACK_HIGH, S_RX_ACK_LOW
  } bus_phase_e;

  typedef enum logic {ROW_TICK, ROW_REG} row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    item_t       it;
    int          reps;
    logic        sda_rand;
    logic        typed;
    result_t     want;
    logic        reg_sel;
    logic [15:0] reg_val;
  } plan_row_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;   // op[2:0], data_byte[10:3], read_not_write[11], send_nack[12], sda_in[13]
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;   // scl_out[0], sda_out[1], busy_res[2], done_res[3], rx_byte[11:4],
                          // nack_seen[12], rejected[13]
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  i2c_master_byte_engine u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // engine state as the predictor sees it
  bus_phase_e  ph;
  logic [3:0]  bit_pos;
  logic [15:0] ticks_left;
  logic [7:0]  shifter;
  logic [7:0]  rx_last;
  logic        scl_q;
  logic        sda_q;
  logic        nack_q;
  logic        ack_q;
  logic [15:0] hp_reg;
  logic [6:0]  addr_reg;

  result_t     pending_ticks[$];
  plan_row_t   plan[$];
  logic [15:0] rate_plan [4] = '{16'd1, 16'd2, 16'd3, 16'd1};

  int   errors;
  int   cycles;
  int   hold_asks;
  int   hold_seen;
  int   hold_left;
  int   stall_left;
  int   open_left;
  int   ready_roll;
  int   send_burst;
  int   txn_step;
  int   data_left;
  logic rd_dir;
  logic full_rate;

  always #1 clk = ~clk;

  function automatic void enter_phase(input bus_phase_e p, input logic scl, input logic sda);
    ph = p;
    ticks_left = (hp_reg == 16'd0) ? 16'd1 : hp_reg;
    scl_q = scl;
    sda_q = sda;
  endfunction

  function automatic void load_tx(input logic [7:0] byte_val);
    shifter = byte_val;
    bit_pos = 4'd7;
    enter_phase(S_TX_SETUP, 1'b0, shifter[7]);
  endfunction

  // closes the current phase, returns 1 when the command is complete
  function automatic logic phase_end(input logic sda_in);
    logic fin;
    fin = 1'b0;
    case (ph)
      S_START_A:  enter_phase(S_START_B, 1'b1, 1'b0);
      S_START_B:  enter_phase(S_START_C, 1'b0, 1'b0);
      S_STOP_A:   enter_phase(S_STOP_B, 1'b1, 1'b0);
      S_STOP_B:   enter_phase(S_STOP_C, 1'b1, 1'b1);
      S_TX_SETUP: enter_phase(S_TX_HIGH, 1'b1, sda_q);
      S_TX_HIGH:  enter_phase(S_TX_LOW, 1'b0, sda_q);
      S_TX_LOW: begin
        if (bit_pos == 4'd0) begin
          enter_phase(S_TX_ACK_HIGH, 1'b1, 1'b1);
        end else begin
          bit_pos = bit_pos - 4'd1;
          enter_phase(S_TX_SETUP, 1'b0, shifter[bit_pos[2:0]]);
        end
      end
      S_TX_ACK_HIGH: begin
        nack_q = sda_in;
        enter_phase(S_TX_ACK_LOW, 1'b0, 1'b1);
      end
      S_RX_HIGH: begin
        shifter = {shifter[6:0], sda_in};
        enter_phase(S_RX_LOW, 1'b0, 1'b1);
      end
      S_RX_LOW: begin
        if (bit_pos == 4'd0) begin
          enter_phase(S_RX_ACK_HIGH, 1'b1, ack_q);
        end else begin
          bit_pos = bit_pos - 4'd1;
          enter_phase(S_RX_HIGH, 1'b1, 1'b1);
        end
      end
      S_RX_ACK_HIGH: enter_phase(S_RX_ACK_LOW, 1'b0, ack_q);
      S_RX_ACK_LOW: begin
        rx_last = shifter;
        ph = S_IDLE;
        fin = 1'b1;
      end
      // last phase of start, stop and byte write
      default: begin
        ph = S_IDLE;
        fin = 1'b1;
      end
    endcase
    return fin;
  endfunction

  function automatic result_t bus_tick(input item_t it);
    result_t r;
    r = '0;
    if (it.op >= OP_START && it.op <= OP_STOP) begin
      if (ph != S_IDLE) begin
        r.rejected = 1'b1;
      end else begin
        case (it.op)
          OP_START: enter_phase(S_START_A, 1'b1, 1'b1);
          OP_ADDR:  load_tx({addr_reg, it.read_not_write});
          OP_WRITE: load_tx(it.data_byte);
          OP_READ: begin
            shifter = 8'h00;
            bit_pos = 4'd7;
            ack_q = it.send_nack;
            enter_phase(S_RX_HIGH, 1'b1, 1'b1);
          end
          default: enter_phase(S_STOP_A, 1'b0, 1'b0);
        endcase
      end
    end
    // lines show the levels of the phase in force once any command of the tick has been entered
    r.scl_out = scl_q;
    r.sda_out = sda_q;
    if (ph != S_IDLE) begin
      if (ticks_left > 16'd0) ticks_left = ticks_left - 16'd1;
      if (ticks_left == 16'd0) r.done_res = phase_end(it.sda_in);
    end
    r.busy_res  = (ph != S_IDLE);
    r.rx_byte   = rx_last;
    r.nack_seen = nack_q;
    return r;
  endfunction

  function automatic item_t mk_item(input logic [2:0] op, input logic [7:0] data,
                                    input logic rnw, input logic nack, input logic sda);
    item_t it;
    it.op = op;
    it.data_byte = data;
    it.read_not_write = rnw;
    it.send_nack = nack;
    it.sda_in = sda;
    return it;
  endfunction

  function automatic result_t bus_view(input logic scl, input logic sda, input logic busy,
                                       input logic done, input logic [7:0] rx,
                                       input logic nack, input logic rej);
    result_t r;
    r.scl_out = scl;
    r.sda_out = sda;
    r.busy_res = busy;
    r.done_res = done;
    r.rx_byte = rx;
    r.nack_seen = nack;
    r.rejected = rej;
    return r;
  endfunction

  function automatic string show(input result_t r);
    return $sformatf("scl %b sda %b busy %b done %b rx %h nack %b rej %b", r.scl_out,
                     r.sda_out, r.busy_res, r.done_res, r.rx_byte, r.nack_seen, r.rejected);
  endfunction

  function automatic void add_ticks(input item_t it, input int reps, input logic sda_rand);
    plan_row_t r;
    r = '0;
    r.kind = ROW_TICK;
    r.it = it;
    r.reps = reps;
    r.sda_rand = sda_rand;
    plan.push_back(r);
  endfunction

  function automatic void add_checked(input item_t it, input result_t want);
    plan_row_t r;
    r = '0;
    r.kind = ROW_TICK;
    r.it = it;
    r.reps = 1;
    r.typed = 1'b1;
    r.want = want;
    plan.push_back(r);
  endfunction

  function automatic void add_reg(input logic sel, input logic [15:0] val);
    plan_row_t r;
    r = '0;
    r.kind = ROW_REG;
    r.reg_sel = sel;
    r.reg_val = val;
    plan.push_back(r);
  endfunction

  function automatic item_t random_tick();
    return mk_item(OP_TICK, 8'($urandom), 1'($urandom), 1'($urandom), 1'($urandom));
  endfunction

  // mostly whole transactions with random content, some noise and broken sequences
  function automatic item_t next_item();
    item_t it;
    int roll;
    it = random_tick();
    if (ph == S_TX_ACK_HIGH && $urandom_range(0, 9) < 8) it.sda_in = 1'b0;
    roll = $urandom_range(0, 99);
    if (ph != S_IDLE) begin
      if (roll < 8) it.op = 3'($urandom_range(OP_START, OP_STOP));
      else if (roll < 16) it.op = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
    end else if (roll < 10) begin
      it.op = 3'($urandom);
    end else if (roll >= 20) begin
      case (txn_step)
        0: begin
          it.op = OP_START;
          txn_step = 1;
        end
        1: begin
          it.op = OP_ADDR;
          rd_dir = it.read_not_write;
          data_left = $urandom_range(1, 3);
          txn_step = 2;
        end
        default: begin
          // host ends the transaction on a nack
          if (nack_q || data_left == 0) begin
            it.op = OP_STOP;
            txn_step = 0;
          end else begin
            it.op = rd_dir ? OP_READ : OP_WRITE;
            data_left--;
          end
        end
      endcase
    end
    return it;
  endfunction

  function automatic int pick_gap();
    int roll;
    if (full_rate) return 0;
    if (send_burst > 0) begin
      send_burst--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 4) begin
      send_burst = $urandom_range(20, 60);
      return 0;
    end
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 2);
    if (roll < 96) return $urandom_range(3, 6);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_tick(input item_t it, input logic typed, input result_t want);
    int gap;
    result_t r;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tdata  <= {2'b00, it.sda_in, it.send_nack, it.read_not_write, it.data_byte, it.op};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    r = bus_tick(it);
    pending_ticks.push_back(typed ? want : r);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (pending_ticks.size() != 0) @(posedge clk);
  endtask

  task automatic apb_access(input logic wr, input logic sel, input logic [31:0] data,
                            output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {sel, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_reg(input logic sel);
    logic [31:0] rd;
    logic [31:0] want;
    apb_access(1'b0, sel, 32'h0, rd);
    want = (sel == REG_HALF_PERIOD) ? {16'h0, hp_reg} : {25'h0, addr_reg};
    if (rd !== want) begin
      if (errors < 10) $display("register %0d read %h, expected %h", sel, rd, want);
      errors++;
    end
  endtask

  task automatic set_reg(input logic sel, input logic [15:0] val);
    logic [31:0] rd;
    while (ph != S_IDLE) send_tick(random_tick(), 1'b0, '0);
    wait_drained();
    apb_access(1'b1, sel, {16'h0, val}, rd);
    if (sel == REG_HALF_PERIOD) hp_reg = val;
    else addr_reg = val[6:0];
    check_reg(sel);
  endtask

  task automatic check_result(input logic [15:0] d);
    result_t got;
    result_t want;
    got = bus_view(d[0], d[1], d[2], d[3], d[11:4], d[12], d[13]);
    if (pending_ticks.size() == 0) begin
      if (errors < 10) $display("transfer with nothing pending: %s", show(got));
      errors++;
    end else begin
      want = pending_ticks.pop_front();
      if (got !== want) begin
        if (errors < 10) begin
          $display("mismatch expected %s", show(want));
          $display("         actual   %s", show(got));
        end
        errors++;
      end
    end
  endtask

  // receiver side: random stalls, open stretches and one long hold on request
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) check_result(m_tdata);
      if (hold_seen != hold_asks) begin
        hold_seen = hold_asks;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (full_rate) begin
        m_tready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else if (open_left > 0) begin
        open_left--;
        m_tready <= 1'b1;
      end else begin
        ready_roll = $urandom_range(0, 99);
        if (ready_roll < 60) begin
          m_tready <= 1'b1;
        end else if (ready_roll < 88) begin
          stall_left = $urandom_range(1, 3);
          m_tready <= 1'b0;
        end else if (ready_roll < 95) begin
          stall_left = $urandom_range(10, 40);
          m_tready <= 1'b0;
        end else begin
          open_left = $urandom_range(30, 80);
          m_tready <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    item_t it;
    clk = 1'b0;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    m_tready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    errors = 0;
    cycles = 0;
    hold_asks = 0;
    hold_seen = 0;
    hold_left = 0;
    stall_left = 0;
    open_left = 0;
    send_burst = 0;
    txn_step = 0;
    data_left = 0;
    rd_dir = 1'b0;
    full_rate = 1'b0;

    ph = S_IDLE;
    bit_pos = 4'd0;
    ticks_left = 16'd0;
    shifter = 8'h00;
    rx_last = 8'h00;
    scl_q = 1'b1;
    sda_q = 1'b1;
    nack_q = 1'b0;
    ack_q = 1'b0;
    hp_reg = HALF_PERIOD_RESET;
    addr_reg = 7'd0;

    // idle after reset, lines released; spare op codes act as plain ticks
    add_checked(mk_item(OP_TICK, 8'h00, 1'b0, 1'b0, 1'b0),
                bus_view(1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0));
    add_checked(mk_item(OP_SPARE_LO, 8'hff, 1'b1, 1'b1, 1'b1),
                bus_view(1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0));
    add_checked(mk_item(OP_SPARE_HI, 8'h00, 1'b0, 1'b0, 1'b1),
                bus_view(1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0));
    // zero half period counts as one tick per phase
    add_reg(REG_HALF_PERIOD, 16'd0);
    add_reg(REG_TARGET_ADDR, 16'd127);
    add_checked(mk_item(OP_START, 8'h00, 1'b0, 1'b0, 1'b0),
                bus_view(1'b1, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0));
    // command while busy is dropped
    add_checked(mk_item(OP_WRITE, 8'h5a, 1'b0, 1'b0, 1'b0),
                bus_view(1'b1, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 1'b1));
    add_checked(mk_item(OP_TICK, 8'h00, 1'b0, 1'b0, 1'b0),
                bus_view(1'b0, 1'b0, 1'b0, 1'b1, 8'h00, 1'b0, 1'b0));
    add_ticks(mk_item(OP_ADDR, 8'h00, 1'b0, 1'b0, 1'b0), 1, 1'b0);
    add_ticks(mk_item(OP_TICK, 8'h00, 1'b0, 1'b0, 1'b0), 25, 1'b0);
    add_ticks(mk_item(OP_WRITE, 8'hff, 1'b0, 1'b0, 1'b1), 1, 1'b0);
    add_ticks(mk_item(OP_TICK, 8'h00, 1'b0, 1'b0, 1'b1), 25, 1'b0);
    add_checked(mk_item(OP_TICK, 8'h00, 1'b0, 1'b0, 1'b0),
                bus_view(1'b0, 1'b1, 1'b0, 1'b0, 8'h00, 1'b1, 1'b0));
    add_ticks(mk_item(OP_WRITE, 8'h00, 1'b0, 1'b0, 1'b0), 1, 1'b0);
    add_ticks(mk_item(OP_TICK, 8'h00, 1'b0, 1'b0, 1'b0), 25, 1'b0);
    add_ticks(mk_item(OP_READ, 8'h00, 1'b0, 1'b0, 1'b1), 1, 1'b0);
    add_ticks(mk_item(OP_TICK, 8'h00, 1'b0, 1'b0, 1'b1), 17, 1'b0);
    add_checked(mk_item(OP_TICK, 8'h00, 1'b0, 1'b0, 1'b0),
                bus_view(1'b0, 1'b0, 1'b0, 1'b0, 8'hff, 1'b0, 1'b0));
    add_ticks(mk_item(OP_READ, 8'h00, 1'b0, 1'b1, 1'b0), 1, 1'b0);
    add_ticks(mk_item(OP_TICK, 8'h00, 1'b0, 1'b0, 1'b0), 17, 1'b0);
    add_checked(mk_item(OP_TICK, 8'h00, 1'b0, 1'b0, 1'b0),
                bus_view(1'b0, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0));
    add_ticks(mk_item(OP_READ, 8'h00, 1'b0, 1'b0, 1'b0), 1, 1'b1);
    add_ticks(mk_item(OP_TICK, 8'h00, 1'b0, 1'b0, 1'b0), 17, 1'b1);
    add_ticks(mk_item(OP_STOP, 8'h00, 1'b0, 1'b0, 1'b0), 1, 1'b0);
    add_ticks(mk_item(OP_TICK, 8'h00, 1'b0, 1'b0, 1'b0), 2, 1'b0);
    add_reg(REG_TARGET_ADDR, 16'd0);
    add_ticks(mk_item(OP_ADDR, 8'h00, 1'b1, 1'b0, 1'b0), 1, 1'b0);
    add_ticks(mk_item(OP_TICK, 8'h00, 1'b0, 1'b0, 1'b0), 25, 1'b1);

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    check_reg(REG_HALF_PERIOD);
    check_reg(REG_TARGET_ADDR);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_REG) begin
        set_reg(plan[i].reg_sel, plan[i].reg_val);
      end else begin
        // long tick runs go back to back with the receiver always ready
        full_rate = (plan[i].reps > 20);
        for (int k = 0; k < plan[i].reps; k++) begin
          it = plan[i].it;
          if (plan[i].sda_rand) it.sda_in = 1'($urandom);
          send_tick(it, plan[i].typed, plan[i].want);
        end
      end
    end
    full_rate = 1'b0;

    foreach (rate_plan[p]) begin
      set_reg(REG_HALF_PERIOD, rate_plan[p]);
      set_reg(REG_TARGET_ADDR, 16'($urandom_range(0, 127)));
      for (int n = 0; n < RAND_PER_SETTING; n++) begin
        // receiver holds off while ticks keep coming, so the output stages fill
        if (p == 0 && n == 20) hold_asks++;
        if (p == 1 && n == 50) wait_drained();
        send_tick(next_item(), 1'b0, '0);
      end
    end

    wait_drained();
    repeat (4) @(posedge clk);
    if (errors == 0 && pending_ticks.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
